// File: rtl/npr_pkg.sv
package npr_pkg;

    // request kinds on the input tuser
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_STOP  = 2'd1;

    // status codes
    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_ACTIVE     = 3'd1;
    localparam logic [2:0] STAT_NOT_ACTIVE = 3'd2;
    localparam logic [2:0] STAT_EMPTY      = 3'd3;
    localparam logic [2:0] STAT_MISMATCH   = 3'd4;
    localparam logic [2:0] STAT_OVERFLOW   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_SKIP_COUNT      = 2'd0;
    localparam logic [1:0] CFG_TIME_ENABLE     = 2'd1;
    localparam logic [1:0] CFG_COUNTERS_ENABLE = 2'd2;
    localparam logic [1:0] CFG_COUNTERS_USED   = 2'd3;

    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 432;

    typedef struct packed {
        logic spoiled;
        logic skipped;
        logic active;
    } npr_flags_t;

    typedef struct packed {
        logic [31:0] enter;
        logic [31:0] skips;
        logic [63:0] sum;
        logic [47:0] tmin;
        logic [47:0] tmax;
        logic [63:0] mean;
        logic [63:0] sqd;
    } npr_stats_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TOP,
        ST_EXEC,
        ST_LSTK,
        ST_LFRD,
        ST_LFWR,
        ST_LCRD,
        ST_LCWR,
        ST_TIME,
        ST_TWAIT,
        ST_FIN,
        ST_OUT
    } npr_state_t;

    typedef enum logic [2:0] {
        WF_IDLE,
        WF_DIV,
        WF_MEAN,
        WF_EMAG,
        WF_MUL,
        WF_FIN,
        WF_DONE
    } npr_wf_state_t;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

endpackage

// File: rtl/npr_ram.sv
module npr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/npr_welford.sv
module npr_welford import npr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [47:0] x,
    input  npr_stats_t rec_in,
    output logic       done,
    output npr_stats_t rec_out
);

    npr_wf_state_t state_reg, state_next;

    npr_stats_t  rec_reg;
    logic [63:0] xf_reg;
    logic        neg_reg;
    logic [63:0] dmag_reg;
    logic [31:0] n_reg;
    logic        nz_reg;
    logic [31:0] rem_reg;
    logic [63:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] emag_reg;
    logic [63:0] pp_reg;
    logic [127:0] acc_reg;
    logic [2:0]  k_reg;
    logic [1:0]  sh_reg;

    logic [63:0] xf_c;
    logic        neg_c;
    logic [63:0] dmag_c;
    npr_stats_t  rec_ld;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        ge;
    logic [31:0] a_half;
    logic [31:0] b_half;
    logic [63:0] pp_c;
    logic [127:0] pp_shifted;
    logic [63:0] prod;

    always_comb
    begin
        xf_c    = {x, 16'b0};
        neg_c   = xf_c < rec_in.mean;
        dmag_c  = neg_c ? rec_in.mean - xf_c : xf_c - rec_in.mean;
        // record with sum, maximum and minimum already updated
        rec_ld      = rec_in;
        rec_ld.sum  = sat_add64(rec_in.sum, {16'b0, x});
        rec_ld.tmax = (x > rec_in.tmax) ? x : rec_in.tmax;
        rec_ld.tmin = (x < rec_in.tmin) ? x : rec_in.tmin;
        rem_sh  = {rem_reg, quo_reg[63]};
        rem_sub = rem_sh - {1'b0, n_reg};
        ge      = rem_sh >= {1'b0, n_reg};
        a_half  = k_reg[1] ? dmag_reg[63:32] : dmag_reg[31:0];
        b_half  = k_reg[0] ? emag_reg[63:32] : emag_reg[31:0];
        pp_c    = 64'(a_half) * 64'(b_half);
        case (sh_reg)
            2'd0:    pp_shifted = {64'b0, pp_reg};
            2'd1:    pp_shifted = {32'b0, pp_reg, 32'b0};
            2'd2:    pp_shifted = {pp_reg, 64'b0};
            default: pp_shifted = '0;
        endcase
        prod = (acc_reg[127:80] != '0) ? '1 : acc_reg[79:16];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            WF_IDLE:
            begin
                if (start)
                begin
                    state_next = (rec_in.enter > rec_in.skips) ? WF_DIV : WF_MEAN;
                end
            end
            WF_DIV:  if (cnt_reg == 6'd63) state_next = WF_MEAN;
            WF_MEAN: state_next = WF_EMAG;
            WF_EMAG: state_next = WF_MUL;
            WF_MUL:  if (k_reg == 3'd4) state_next = WF_FIN;
            WF_FIN:  state_next = WF_DONE;
            WF_DONE: state_next = WF_IDLE;
            default: state_next = WF_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        done    = (state_reg == WF_DONE);
        rec_out = rec_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WF_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            WF_IDLE:
            begin
                if (start)
                begin
                    rec_reg      <= rec_ld;
                    xf_reg       <= xf_c;
                    neg_reg      <= neg_c;
                    dmag_reg     <= dmag_c;
                    n_reg        <= rec_in.enter - rec_in.skips;
                    nz_reg       <= rec_in.enter > rec_in.skips;
                    quo_reg      <= dmag_c;
                    rem_reg      <= '0;
                    cnt_reg      <= '0;
                end
            end
            WF_DIV:
            begin
                rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
                quo_reg <= {quo_reg[62:0], ge};
                cnt_reg <= cnt_reg + 6'd1;
            end
            WF_MEAN:
            begin
                if (nz_reg)
                begin
                    rec_reg.mean <= neg_reg ? rec_reg.mean - quo_reg : rec_reg.mean + quo_reg;
                end
            end
            WF_EMAG:
            begin
                emag_reg <= neg_reg ? rec_reg.mean - xf_reg : xf_reg - rec_reg.mean;
                acc_reg  <= '0;
                k_reg    <= '0;
            end
            WF_MUL:
            begin
                if (k_reg != 3'd0)
                begin
                    acc_reg <= acc_reg + pp_shifted;
                end
                if (k_reg != 3'd4)
                begin
                    pp_reg <= pp_c;
                    sh_reg <= 2'({1'b0, k_reg[1]} + {1'b0, k_reg[0]});
                end
                k_reg <= k_reg + 3'd1;
            end
            WF_FIN:
            begin
                rec_reg.sqd <= sat_add64(rec_reg.sqd, prod);
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/nested_region_profiler_core.sv
// nested region profiler: each input word is a start, stop or read event for one region,
// and each event returns exactly one result word with the region's statistics after the
// event. all per-region state sits in single-port-read synchronous memories; after reset
// a clearing pass over REGIONS*COUNTERS addresses initialises the statistics, flag and
// counter memories and no word is taken until it ends (configuration writes are taken at
// any time). an event does a lookup and a result, plus, when counters are enabled, a
// stack read, a flag read and a flag update and then a read and a write per used counter
// (counters_used capped at COUNTERS) for each open region walked, plus on a timed stop
// a 64-step serial divide for the mean (left out when the region has no counted entry)
// and four 32x32 partial products accumulated for the squared distance. a finished
// result waits in the output register while the next word is accepted.
module nested_region_profiler_core import npr_pkg::*; #(
    parameter int REGIONS     = 64,
    parameter int COUNTERS    = 4,
    parameter int STACK_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // region_id[5:0], now_ticks[53:6], delta_zero..delta_three[181:54], counter_select[183:182]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status[2:0], was_skipped[3], nest_depth[8:4], enter_total[40:9], skip_total[72:41],
    // spoiled_flag[73], time_max[121:74], time_min[169:122], time_sum[233:170],
    // time_mean[297:234], time_sq_dist[361:298], counter_total[425:362], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_wen,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    localparam int RW = $clog2(REGIONS);
    localparam int CN = REGIONS * COUNTERS;
    localparam int CA = $clog2(CN);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int JW = $clog2(COUNTERS + 1);
    localparam int SSW = $bits(npr_stats_t);

    // configuration
    logic [15:0] skip_count_reg;
    logic        time_en_reg;
    logic        cnt_en_reg;
    logic [2:0]  cnt_used_reg;

    // control
    npr_state_t    state_reg, state_next;
    logic [CA-1:0] clr_cnt_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] lim_reg;
    logic [CW-1:0] i_reg;
    logic [JW-1:0] j_reg;
    logic          spoil_reg;
    logic          do_time_reg;
    logic          m_tvalid_reg;

    // captured event and working values
    logic [1:0]            kind_reg;
    logic [RW-1:0]         r_reg;
    logic [47:0]           now_reg;
    logic [31:0]           delta_reg [4];
    logic [1:0]            sel_reg;
    logic [RW-1:0]         top_reg;
    npr_flags_t            rflags_reg;
    logic [2:0]            status_reg;
    logic [RW-1:0]         o_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // memory ports
    logic          stats_we, stats_re;
    logic [RW-1:0] stats_waddr, stats_raddr;
    npr_stats_t    stats_wdata, stats_rdata;
    logic [SSW-1:0] stats_rbits;
    logic          flags_we, flags_re;
    logic [RW-1:0] flags_waddr, flags_raddr;
    npr_flags_t    flags_wdata, flags_rdata;
    logic [2:0]    flags_rbits;
    logic          stamp_we, stamp_re;
    logic [RW-1:0] stamp_waddr, stamp_raddr;
    logic [47:0]   stamp_wdata, stamp_rdata;
    logic          stack_we, stack_re;
    logic [SW-1:0] stack_waddr, stack_raddr;
    logic [RW-1:0] stack_wdata, stack_rdata;
    logic          ctr_we, ctr_re;
    logic [CA-1:0] ctr_waddr, ctr_raddr;
    logic [63:0]   ctr_wdata, ctr_rdata;

    // welford unit
    logic       wf_start, wf_done;
    logic [47:0] wf_x;
    npr_stats_t wf_rec;

    // decode
    logic [RW-1:0] r_in;
    npr_flags_t    topfl;
    logic          start_skip, start_ok, stop_sk, stop_ok, mism;
    logic          loop_go, time_go, last_i, last_j, spoil_now, sel_ok, out_load;
    logic [2:0]    ex_status;
    logic [JW-1:0] used_w;
    logic [31:0]   d_sel;
    logic [CA-1:0] ctr_oaddr, ctr_saddr;
    npr_state_t    after_loop;
    npr_stats_t    start_rec;

    assign stats_rdata = npr_stats_t'(stats_rbits);
    assign flags_rdata = npr_flags_t'(flags_rbits);

    // region id taken modulo the region count
    always_comb
    begin
        r_in = '0;
        for (int k = 0; k < 64; k++)
        begin
            if (s_tdata[5:0] == 6'(k))
            begin
                r_in = RW'(k % REGIONS);
            end
        end
    end

    always_comb
    begin
        topfl      = flags_rdata;
        used_w     = (int'(cnt_used_reg) > COUNTERS) ? JW'(COUNTERS) : JW'(cnt_used_reg);
        start_skip = ((count_reg != '0) && topfl.skipped) ||
                     (stats_rdata.enter < {16'b0, skip_count_reg});
        start_ok   = (kind_reg == REQ_START) && !rflags_reg.active &&
                     (count_reg < CW'(STACK_DEPTH));
        stop_sk    = (kind_reg == REQ_STOP) && rflags_reg.skipped;
        mism       = cnt_en_reg && (count_reg == CW'(1)) && (top_reg != r_reg);
        stop_ok    = (kind_reg == REQ_STOP) && !rflags_reg.skipped && rflags_reg.active &&
                     (count_reg != '0) && !mism;
        ex_status  = STAT_OK;
        if (kind_reg == REQ_START)
        begin
            if (rflags_reg.active)
                ex_status = STAT_ACTIVE;
            else if (count_reg >= CW'(STACK_DEPTH))
                ex_status = STAT_OVERFLOW;
        end
        else if ((kind_reg == REQ_STOP) && !rflags_reg.skipped)
        begin
            if (!rflags_reg.active)
                ex_status = STAT_NOT_ACTIVE;
            else if (count_reg == '0)
                ex_status = STAT_EMPTY;
            else if (mism)
                ex_status = STAT_MISMATCH;
        end
        loop_go   = (start_ok && !start_skip && cnt_en_reg && (count_reg != '0)) ||
                    (stop_ok && cnt_en_reg);
        time_go   = stop_ok && time_en_reg;
        last_i    = CW'(i_reg + CW'(1)) >= lim_reg;
        last_j    = JW'(j_reg + JW'(1)) >= used_w;
        spoil_now = spoil_reg && !last_i;
        d_sel     = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (int'(j_reg) == k)
            begin
                d_sel = delta_reg[k];
            end
        end
        ctr_oaddr  = CA'(int'(o_reg) * COUNTERS + int'(j_reg));
        ctr_saddr  = CA'(int'(r_reg) * COUNTERS + int'(sel_reg));
        sel_ok     = int'(sel_reg) < COUNTERS;
        after_loop = do_time_reg ? ST_TIME : ST_FIN;
        out_load   = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
        start_rec  = stats_rdata;
        if (stats_rdata.enter != '1)
            start_rec.enter = stats_rdata.enter + 32'd1;
        if (start_skip && (stats_rdata.skips != '1))
            start_rec.skips = stats_rdata.skips + 32'd1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == CA'(CN - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_TOP;
            ST_TOP:   state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (loop_go)
                    state_next = ST_LSTK;
                else if (time_go)
                    state_next = ST_TIME;
                else
                    state_next = ST_FIN;
            end
            ST_LSTK:  state_next = ST_LFRD;
            ST_LFRD:  state_next = ST_LFWR;
            ST_LFWR:
            begin
                if (used_w != '0)
                    state_next = ST_LCRD;
                else
                    state_next = last_i ? after_loop : ST_LSTK;
            end
            ST_LCRD:  state_next = ST_LCWR;
            ST_LCWR:
            begin
                if (!last_j)
                    state_next = ST_LCRD;
                else
                    state_next = last_i ? after_loop : ST_LSTK;
            end
            ST_TIME:  state_next = ST_TWAIT;
            ST_TWAIT: if (wf_done) state_next = ST_FIN;
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // memory strobes and handshake outputs
    always_comb
    begin
        stats_we = 1'b0; stats_waddr = r_reg; stats_wdata = stats_rdata;
        stats_re = 1'b0; stats_raddr = r_reg;
        flags_we = 1'b0; flags_waddr = r_reg; flags_wdata = rflags_reg;
        flags_re = 1'b0; flags_raddr = r_reg;
        stamp_we = 1'b0; stamp_waddr = r_reg; stamp_wdata = now_reg;
        stamp_re = 1'b0; stamp_raddr = r_in;
        stack_we = 1'b0; stack_waddr = SW'(count_reg); stack_wdata = r_reg;
        stack_re = 1'b0; stack_raddr = SW'(i_reg);
        ctr_we   = 1'b0; ctr_waddr = ctr_oaddr; ctr_wdata = ctr_rdata + {32'b0, d_sel};
        ctr_re   = 1'b0; ctr_raddr = ctr_oaddr;
        wf_start = (state_reg == ST_TIME);
        wf_x     = now_reg - stamp_rdata;
        s_tready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_CLEAR:
            begin
                stats_we    = int'(clr_cnt_reg) < REGIONS;
                stats_waddr = RW'(clr_cnt_reg);
                stats_wdata = '{enter: '0, skips: '0, sum: '0, tmin: '1, tmax: '0,
                                mean: '0, sqd: '0};
                flags_we    = int'(clr_cnt_reg) < REGIONS;
                flags_waddr = RW'(clr_cnt_reg);
                flags_wdata = '0;
                ctr_we      = 1'b1;
                ctr_waddr   = clr_cnt_reg;
                ctr_wdata   = '0;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    stack_re    = 1'b1;
                    stack_raddr = SW'(count_reg - CW'(1));
                    flags_re    = 1'b1;
                    flags_raddr = r_in;
                    stats_re    = 1'b1;
                    stats_raddr = r_in;
                    stamp_re    = 1'b1;
                end
            end
            ST_TOP:
            begin
                flags_re    = 1'b1;
                flags_raddr = stack_rdata;
            end
            ST_EXEC:
            begin
                if (start_ok)
                begin
                    stats_we    = 1'b1;
                    stats_wdata = start_rec;
                    flags_we    = 1'b1;
                    flags_wdata = '{spoiled: rflags_reg.spoiled, skipped: start_skip,
                                    active: 1'b1};
                    stack_we    = 1'b1;
                    stamp_we    = !start_skip && time_en_reg;
                end
                else if (stop_sk || stop_ok)
                begin
                    flags_we           = 1'b1;
                    flags_wdata.active = 1'b0;
                end
            end
            ST_LSTK: stack_re = 1'b1;
            ST_LFRD:
            begin
                flags_re    = 1'b1;
                flags_raddr = stack_rdata;
            end
            ST_LFWR:
            begin
                // outer regions get marked spoiled on a nested stop
                flags_we            = spoil_now;
                flags_waddr         = o_reg;
                flags_wdata         = flags_rdata;
                flags_wdata.spoiled = 1'b1;
            end
            ST_LCRD: ctr_re = 1'b1;
            ST_LCWR: ctr_we = 1'b1;
            ST_TWAIT:
            begin
                stats_we    = wf_done;
                stats_wdata = wf_rec;
            end
            ST_FIN:
            begin
                stats_re  = 1'b1;
                flags_re  = 1'b1;
                ctr_re    = sel_ok;
                ctr_raddr = ctr_saddr;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_count_reg <= '0;
            time_en_reg    <= 1'b1;
            cnt_en_reg     <= 1'b0;
            cnt_used_reg   <= '0;
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            count_reg      <= '0;
            lim_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            spoil_reg      <= 1'b0;
            do_time_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_SKIP_COUNT:      skip_count_reg <= cfg_data;
                    CFG_TIME_ENABLE:     time_en_reg    <= cfg_data[0];
                    CFG_COUNTERS_ENABLE: cnt_en_reg     <= cfg_data[0];
                    CFG_COUNTERS_USED:   cnt_used_reg   <= cfg_data[2:0];
                    default:             skip_count_reg <= skip_count_reg;
                endcase
            end
            case (state_reg)
                ST_CLEAR: clr_cnt_reg <= clr_cnt_reg + CA'(1);
                ST_EXEC:
                begin
                    if (start_ok)
                        count_reg <= count_reg + CW'(1);
                    else if ((stop_sk && (count_reg != '0)) || stop_ok)
                        count_reg <= count_reg - CW'(1);
                    lim_reg     <= count_reg;
                    spoil_reg   <= stop_ok;
                    do_time_reg <= time_go;
                    i_reg       <= '0;
                end
                ST_LFWR:
                begin
                    j_reg <= '0;
                    if (used_w == '0)
                        i_reg <= i_reg + CW'(1);
                end
                ST_LCWR:
                begin
                    if (!last_j)
                        j_reg <= j_reg + JW'(1);
                    else
                        i_reg <= i_reg + CW'(1);
                end
                default:
                begin
                end
            endcase
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_reg     <= s_tuser;
                    r_reg        <= r_in;
                    now_reg      <= s_tdata[53:6];
                    delta_reg[0] <= s_tdata[85:54];
                    delta_reg[1] <= s_tdata[117:86];
                    delta_reg[2] <= s_tdata[149:118];
                    delta_reg[3] <= s_tdata[181:150];
                    sel_reg      <= s_tdata[183:182];
                end
            end
            ST_TOP:
            begin
                rflags_reg <= flags_rdata;
                top_reg    <= stack_rdata;
            end
            ST_EXEC: status_reg <= ex_status;
            ST_LFRD: o_reg <= stack_rdata;
            ST_OUT:
            begin
                if (out_load)
                begin
                    m_tdata_reg <= {6'b0, (sel_ok ? ctr_rdata : 64'd0), stats_rdata.sqd,
                                    stats_rdata.mean, stats_rdata.sum, stats_rdata.tmin,
                                    stats_rdata.tmax, flags_rdata.spoiled, stats_rdata.skips,
                                    stats_rdata.enter, 5'(count_reg), flags_rdata.skipped,
                                    status_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // per-region statistics
    npr_ram #(.WIDTH(SSW), .DEPTH(REGIONS)) u_stats_ram (
        .clk(clk), .we(stats_we), .waddr(stats_waddr), .wdata(stats_wdata),
        .re(stats_re), .raddr(stats_raddr), .rdata(stats_rbits)
    );

    // active, skipped and spoiled bits
    npr_ram #(.WIDTH(3), .DEPTH(REGIONS)) u_flags_ram (
        .clk(clk), .we(flags_we), .waddr(flags_waddr), .wdata(flags_wdata),
        .re(flags_re), .raddr(flags_raddr), .rdata(flags_rbits)
    );

    // start stamps, not cleared
    npr_ram #(.WIDTH(48), .DEPTH(REGIONS)) u_stamp_ram (
        .clk(clk), .we(stamp_we), .waddr(stamp_waddr), .wdata(stamp_wdata),
        .re(stamp_re), .raddr(stamp_raddr), .rdata(stamp_rdata)
    );

    // open region stack
    npr_ram #(.WIDTH(RW), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .clk(clk), .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
        .re(stack_re), .raddr(stack_raddr), .rdata(stack_rdata)
    );

    // counter totals, region-major
    npr_ram #(.WIDTH(64), .DEPTH(CN)) u_ctr_ram (
        .clk(clk), .we(ctr_we), .waddr(ctr_waddr), .wdata(ctr_wdata),
        .re(ctr_re), .raddr(ctr_raddr), .rdata(ctr_rdata)
    );

    npr_welford u_welford (
        .clk(clk), .rst_n(rst_n), .start(wf_start), .x(wf_x),
        .rec_in(stats_rdata), .done(wf_done), .rec_out(wf_rec)
    );

    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_TOP))
        else $error("accepted word did not start a lookup");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("open region count beyond stack depth");

    a_wf_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        wf_done |-> (state_reg == ST_TWAIT))
        else $error("welford result arrived outside wait state");

    a_loop_cen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LSTK) |-> cnt_en_reg)
        else $error("stack walk without counters enabled");

endmodule

// File: bench/npr_checker.sv
module npr_checker import npr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_wen,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    output int                    fail_count,
    output int                    words_pending
);

    localparam int NREG  = 64;
    localparam int NCNT  = 4;
    localparam int DEPTH = 16;
    localparam logic [47:0] ALL48 = '1;

    typedef struct {
        logic [2:0]  status;
        logic        skipped;
        logic [4:0]  depth;
        logic [31:0] enters;
        logic [31:0] skips;
        logic        spoiled;
        logic [47:0] tmax;
        logic [47:0] tmin;
        logic [63:0] tsum;
        logic [63:0] tmean;
        logic [63:0] tsqd;
        logic [63:0] ctotal;
    } stats_word_t;

    stats_word_t expected_stats[$];

    logic [15:0] skip_first;
    logic        timing_on;
    logic        counting_on;
    logic [2:0]  counters_active;

    logic [31:0] enter_cnt [NREG];
    logic [31:0] skip_cnt  [NREG];
    logic [63:0] dur_sum   [NREG];
    logic [47:0] dur_min   [NREG];
    logic [47:0] dur_max   [NREG];
    logic [63:0] mean_fx   [NREG];
    logic [63:0] sqd_fx    [NREG];
    logic [47:0] stamp     [NREG];
    npr_flags_t  flags     [NREG];
    logic [63:0] ctr_total [NREG*NCNT];
    logic [5:0]  open_ids  [DEPTH];
    logic [4:0]  open_num;

    assign words_pending = expected_stats.size();

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic void accumulate(input logic [5:0] r, input logic [31:0] d [4]);
        int used;
        used = counters_active > NCNT ? NCNT : counters_active;
        for (int j = 0; j < used; j++)
            ctr_total[r*NCNT + j] += 64'(d[j]);
    endfunction

    function automatic void time_stop(input logic [5:0] r, input logic [47:0] now);
        logic [47:0]  x;
        logic [63:0]  xf, m, dmag, emag, n;
        logic [127:0] prod;
        logic         neg;
        x  = now - stamp[r];
        xf = {x, 16'h0};
        m  = mean_fx[r];
        dur_sum[r] = add_sat(dur_sum[r], 64'(x));
        if (x > dur_max[r]) dur_max[r] = x;
        if (x < dur_min[r]) dur_min[r] = x;
        neg  = xf < m;
        dmag = neg ? m - xf : xf - m;
        if (enter_cnt[r] > skip_cnt[r])
        begin
            n = 64'(enter_cnt[r] - skip_cnt[r]);
            m = neg ? m - dmag / n : m + dmag / n;
            mean_fx[r] = m;
        end
        emag = neg ? m - xf : xf - m;
        prod = 128'(dmag) * 128'(emag);
        sqd_fx[r] = add_sat(sqd_fx[r], prod[127:80] != 0 ? '1 : prod[79:16]);
    endfunction

    function automatic logic [2:0] region_start(input logic [5:0] r, input logic [47:0] now,
                                               input logic [31:0] d [4]);
        logic skip;
        if (flags[r].active) return STAT_ACTIVE;
        if (open_num >= DEPTH) return STAT_OVERFLOW;
        skip = open_num > 0 && flags[open_ids[open_num-1]].skipped;
        if (!skip && enter_cnt[r] < 32'(skip_first)) skip = 1'b1;
        if (enter_cnt[r] != '1) enter_cnt[r]++;
        if (skip && skip_cnt[r] != '1) skip_cnt[r]++;
        flags[r].active  = 1'b1;
        flags[r].skipped = skip;
        if (!skip && counting_on)
            for (int i = 0; i < open_num; i++)
                accumulate(open_ids[i], d);
        open_ids[open_num] = r;
        open_num++;
        if (!skip && timing_on) stamp[r] = now;
        return STAT_OK;
    endfunction

    function automatic logic [2:0] region_stop(input logic [5:0] r, input logic [47:0] now,
                                              input logic [31:0] d [4]);
        logic [4:0] remaining;
        if (flags[r].skipped)
        begin
            flags[r].active = 1'b0;
            if (open_num > 0) open_num--;
            return STAT_OK;
        end
        if (!flags[r].active) return STAT_NOT_ACTIVE;
        if (open_num == 0) return STAT_EMPTY;
        remaining = open_num - 1;
        if (counting_on && remaining == 0 && open_ids[0] != r) return STAT_MISMATCH;
        flags[r].active = 1'b0;
        open_num = remaining;
        if (counting_on)
        begin
            if (remaining == 0)
                accumulate(r, d);
            else
                for (int i = 0; i <= remaining && i < DEPTH; i++)
                begin
                    accumulate(open_ids[i], d);
                    if (i < remaining) flags[open_ids[i]].spoiled = 1'b1;
                end
        end
        if (timing_on) time_stop(r, now);
        return STAT_OK;
    endfunction

    function automatic stats_word_t profile_event(input logic [1:0] kind,
                                                  input logic [IN_DATA_W-1:0] w);
        stats_word_t e;
        logic [5:0]  r;
        logic [47:0] now;
        logic [31:0] d [4];
        logic [1:0]  sel;
        r   = w[5:0];
        now = w[53:6];
        for (int j = 0; j < 4; j++) d[j] = w[54 + 32*j +: 32];
        sel = w[183:182];
        e.status = STAT_OK;
        if (kind == REQ_START)     e.status = region_start(r, now, d);
        else if (kind == REQ_STOP) e.status = region_stop(r, now, d);
        e.skipped = flags[r].skipped;
        e.depth   = open_num;
        e.enters  = enter_cnt[r];
        e.skips   = skip_cnt[r];
        e.spoiled = flags[r].spoiled;
        e.tmax    = dur_max[r];
        e.tmin    = dur_min[r];
        e.tsum    = dur_sum[r];
        e.tmean   = mean_fx[r];
        e.tsqd    = sqd_fx[r];
        e.ctotal  = ctr_total[r*NCNT + sel];
        return e;
    endfunction

    function automatic void compare(input string field, input logic [63:0] want,
                                    input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stats_word_t e;
        if (!rst_n)
        begin
            fail_count      = 0;
            skip_first      = 16'd0;
            timing_on       = 1'b1;
            counting_on     = 1'b0;
            counters_active = 3'd0;
            open_num        = 5'd0;
            expected_stats.delete();
            for (int i = 0; i < NREG; i++)
            begin
                enter_cnt[i] = '0;
                skip_cnt[i]  = '0;
                dur_sum[i]   = '0;
                dur_min[i]   = ALL48;
                dur_max[i]   = '0;
                mean_fx[i]   = '0;
                sqd_fx[i]    = '0;
                stamp[i]     = '0;
                flags[i]     = '0;
            end
            for (int i = 0; i < NREG*NCNT; i++) ctr_total[i] = '0;
            for (int i = 0; i < DEPTH; i++) open_ids[i] = '0;
        end
        else
        begin
            // results first: a word leaving on this edge belongs to an older event
            if (m_tvalid && m_tready)
            begin
                if (expected_stats.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = expected_stats.pop_front();
                    compare("status", 64'(e.status), 64'(m_tdata[2:0]));
                    compare("was_skipped", 64'(e.skipped), 64'(m_tdata[3]));
                    compare("nest_depth", 64'(e.depth), 64'(m_tdata[8:4]));
                    compare("enter_total", 64'(e.enters), 64'(m_tdata[40:9]));
                    compare("skip_total", 64'(e.skips), 64'(m_tdata[72:41]));
                    compare("spoiled_flag", 64'(e.spoiled), 64'(m_tdata[73]));
                    compare("time_max", 64'(e.tmax), 64'(m_tdata[121:74]));
                    compare("time_min", 64'(e.tmin), 64'(m_tdata[169:122]));
                    compare("time_sum", e.tsum, m_tdata[233:170]);
                    compare("time_mean", e.tmean, m_tdata[297:234]);
                    compare("time_sq_dist", e.tsqd, m_tdata[361:298]);
                    compare("counter_total", e.ctotal, m_tdata[425:362]);
                end
            end
            if (s_tvalid && s_tready)
                expected_stats.push_back(profile_event(s_tuser, s_tdata));
            if (cfg_wen)
                case (cfg_index)
                    CFG_SKIP_COUNT:      skip_first      = cfg_data;
                    CFG_TIME_ENABLE:     timing_on       = cfg_data[0];
                    CFG_COUNTERS_ENABLE: counting_on     = cfg_data[0];
                    CFG_COUNTERS_USED:   counters_active = cfg_data[2:0];
                    default: ;
                endcase
        end
    end

endmodule

// File: bench/testbench.sv
module testbench;
    import npr_pkg::*;

    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_ODD   = 2'd3;   // unused code, behaves as a read
    localparam int         CYCLE_CAP = 3000000;
    localparam int         HOLD_LEN  = 3000;   // long receiver hold-off
    localparam int         SETTLE    = 400;    // worst event latency with margin

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // region_id[5:0], now_ticks[53:6], delta_zero..delta_three[181:54], counter_select[183:182]
    logic [IN_DATA_W-1:0]  s_tdata;
    // req_type[1:0]
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // status[2:0] .. counter_total[425:362], zero pad
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wen;
    logic [1:0]            cfg_index;
    logic [15:0]           cfg_data;

    int          fail_count;
    int          words_pending;
    int          words_sent;
    int          cycles;
    bit          hold_done;
    int          hold_left;
    logic [47:0] tick_now;
    logic [5:0]  open_guess[$];   // rough picture of the region stack, used only to shape stimulus
    int          depth_goal;

    nested_region_profiler_core u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    npr_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .words_pending(words_pending)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // hard limit on run length
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // a stretch with no idling on either side
    function automatic bit idle_now();
        if (words_sent >= 420 && words_sent < 540) return 1'b0;
        return $urandom_range(99) < 23;
    endfunction

    // receiver: random stalls, and one long hold-off while the sender keeps going
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && words_sent >= 300)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !idle_now();
    end

    // one event word; valid is left high on return so back-to-back words never toggle it
    task automatic send_event(input logic [1:0] kind, input logic [5:0] region);
        logic [31:0] d [4];
        logic [47:0] now;
        int          pick;
        pick = $urandom_range(99);
        for (int j = 0; j < 4; j++)
            d[j] = pick < 8 ? '1 : pick < 12 ? '0 : $urandom();
        pick = $urandom_range(99);
        // mostly a steady clock, sometimes a jump anywhere so elapsed time wraps
        if (pick < 4)      now = '1;
        else if (pick < 7) now = '0;
        else if (pick < 12) now = {16'($urandom_range(16'hffff)), 32'($urandom())};
        else
        begin
            tick_now += 48'($urandom_range(5000));
            now = tick_now;
        end
        while (idle_now())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'($urandom_range(3)), d[3], d[2], d[1], d[0], now, region};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (words_pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] skip_first, input bit timing,
                              input bit counting, input logic [2:0] used);
        logic [15:0] vals [4];
        logic [1:0]  idx  [4];
        vals = '{skip_first, 16'(timing), 16'(counting), 16'(used)};
        idx  = '{CFG_SKIP_COUNT, CFG_TIME_ENABLE, CFG_COUNTERS_ENABLE, CFG_COUNTERS_USED};
        for (int i = 0; i < 4; i++)
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_wen <= 1'b0;
        open_guess.delete();
    endtask

    // mostly properly nested start/stop pairs; the rest is noise
    task automatic random_events(input int count);
        logic [5:0] r;
        bit         fresh;
        for (int n = 0; n < count; n++)
        begin
            if (open_guess.size() == 0)
                depth_goal = $urandom_range(9) == 0 ? $urandom_range(12, 17)
                                                    : $urandom_range(1, 6);
            if ($urandom_range(99) < 82)
            begin
                if (open_guess.size() < depth_goal && $urandom_range(99) < 60)
                begin
                    fresh = 1'b0;
                    while (!fresh)
                    begin
                        r = 6'($urandom_range(63));
                        fresh = 1'b1;
                        foreach (open_guess[i])
                            if (open_guess[i] == r) fresh = 1'b0;
                    end
                    open_guess.push_back(r);
                    send_event(REQ_START, r);
                end
                else if (open_guess.size() > 0)
                    send_event(REQ_STOP, open_guess.pop_back());
                else
                    send_event(REQ_READ, 6'($urandom_range(63)));
            end
            else
            begin
                r = open_guess.size() > 0 && $urandom_range(1)
                    ? open_guess[$urandom_range(open_guess.size() - 1)]
                    : 6'($urandom_range(63));
                send_event(2'($urandom_range(3)), r);
                if (open_guess.size() > 0 && $urandom_range(3) == 0)
                    open_guess.pop_front();   // out-of-order stop pattern
            end
        end
    endtask

    initial
    begin
        cycles     = 0;
        words_sent = 0;
        hold_done  = 1'b0;
        hold_left  = 0;
        tick_now   = 48'd1000;
        depth_goal = 1;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = REQ_START;
        m_tready   = 1'b0;
        cfg_wen    = 1'b0;
        cfg_index  = CFG_SKIP_COUNT;
        cfg_data   = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: stop with nothing open, then one timed pass over every
        // region so that every start stamp holds a written value
        send_event(REQ_STOP, 6'd5);
        send_event(REQ_ODD, 6'd63);
        for (int r = 0; r < 64; r++)
        begin
            send_event(REQ_START, 6'(r));
            send_event(REQ_STOP, 6'(r));
        end
        send_event(REQ_START, 6'd0);
        send_event(REQ_START, 6'd0);                     // already active
        for (int r = 1; r < 17; r++)
            send_event(REQ_START, 6'(r));                // the last overflows
        for (int r = 15; r >= 0; r--)
            send_event(REQ_STOP, 6'(r));
        quiesce();

        // counters on: spoiling by a nested stop, then an outer stop out of order
        set_config(16'd0, 1'b1, 1'b1, 3'd4);
        send_event(REQ_START, 6'd10);
        send_event(REQ_START, 6'd11);
        send_event(REQ_STOP, 6'd10);
        send_event(REQ_STOP, 6'd11);                     // stack mismatch
        send_event(REQ_READ, 6'd10);
        send_event(REQ_STOP, 6'd10);                     // not active
        random_events(110);
        quiesce();

        // entry skipping: double stop of a skipped region empties the stack under
        // an open one
        set_config(16'd2, 1'b1, 1'b1, 3'd2);
        send_event(REQ_START, 6'd20);
        send_event(REQ_STOP, 6'd20);
        send_event(REQ_START, 6'd20);
        send_event(REQ_START, 6'd21);
        send_event(REQ_STOP, 6'd21);
        send_event(REQ_STOP, 6'd21);
        send_event(REQ_STOP, 6'd20);                     // skipped region, status ok
        random_events(110);
        quiesce();

        set_config(16'd0, 1'b0, 1'b1, 3'd7);
        random_events(110);
        quiesce();

        set_config(16'hffff, 1'b1, 1'b0, 3'd1);
        random_events(100);
        quiesce();

        set_config(16'd1, 1'b1, 1'b1, 3'd3);
        random_events(110);
        quiesce();

        set_config(16'd0, 1'b1, 1'b1, 3'd0);
        random_events(60);
        quiesce();

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
rtl/npr_pkg.sv
rtl/npr_ram.sv
rtl/npr_welford.sv
rtl/nested_region_profiler_core.sv
bench/npr_checker.sv
bench/testbench.sv
